FILE: rtl/ndrs_pkg.sv
// Types, constants and register indexes shared by the resonator synth.
`timescale 1ns / 1ps
`default_nettype none

package ndrs_pkg;

	localparam int STATE_BITS    = 48;
	localparam int INDEX_BITS    = 24;
	localparam int MAG_BITS      = 64;
	localparam int MUL_BITS      = 32;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int LEN_BITS      = 25;
	localparam int CMP_BITS      = ((INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS) + 1;
	localparam int ENV_BITS      = 26;
	localparam int DIST_BITS     = 24;
	localparam int XS_BITS       = 25;
	localparam int SAMPLE_BITS   = 24;
	localparam int NOISE_BITS    = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_SPRING  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_COEFF_DAMPING = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_GAIN      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_NOTE_LENGTH   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_INV_SPAN      = 3'd4;

	localparam logic [LEN_BITS-1:0] NOTE_LENGTH_RST = 25'd2;
	localparam logic [31:0]         INV_SPAN_RST    = 32'hffff_ffff;

	localparam logic [MAG_BITS-1:0]  X_ONE     = 64'h1_0000_0000;
	localparam logic [XS_BITS-1:0]   ENV_HALF  = 25'h080_0000;
	localparam logic [ENV_BITS-1:0]  ENV_ONE   = 26'h100_0000;
	localparam logic [ENV_BITS-1:0]  ENV_LIMIT = 26'h200_0000;
	localparam logic [62:0]          SAT_POS   = 63'h7f_ffff;
	localparam logic [62:0]          SAT_NEG   = 63'h80_0000;

	typedef struct packed {
		logic signed [NOISE_BITS-1:0] noise;
		logic                         note_start;
	} ndrs_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last;
	} ndrs_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_X,
		ST_DB_L,
		ST_DB_H,
		ST_SQ,
		ST_SA_L,
		ST_CU,
		ST_SA_H,
		ST_EN_L,
		ST_EN_H,
		ST_GN_L,
		ST_GN_H,
		ST_GN_X,
		ST_OUT
	} ndrs_state_t;

endpackage

`default_nettype wire

FILE: rtl/noise_driven_resonator_synth_core.sv
// Noise-excited resonator with note envelope, built around one shared 32x32 multiplier.
// An accepted transaction steps through ST_X to ST_GN_X and waits in ST_OUT until the output register is free.
// A new transaction is accepted only back in ST_IDLE; eleven products share the one multiplier.
// Input stall stays high from acceptance until the result is loaded into the output register.
// The result waits there without blocking the next input transaction.
// Reset clears position, velocity, sample index and output valid, and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module noise_driven_resonator_synth_core
	import ndrs_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire ndrs_in_t                 in_data,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output ndrs_out_t                     out_data
);

	ndrs_state_t state_q, state_d;

	logic [31:0]           coeff_spring_q;
	logic [31:0]           coeff_damping_q;
	logic [31:0]           out_gain_q;
	logic [LEN_BITS-1:0]   note_length_q;
	logic [31:0]           inv_span_q;

	logic signed [STATE_BITS-1:0] pos_q;
	logic signed [STATE_BITS-1:0] vel_q;
	logic [INDEX_BITS-1:0]        idx_q;
	logic signed [NOISE_BITS-1:0] noise_q;

	logic [MAG_BITS-1:0]   pmag_q, vmag_q;
	logic                  pneg_q, vneg_q;
	logic [DIST_BITS-1:0]  dist_q;
	logic                  dpos_q;
	logic [DIST_BITS-1:0]  sq_q;
	logic [ENV_BITS-1:0]   env_q;
	logic [STATE_BITS-1:0] damp_q, spring_q, vsum_q;
	logic [MAG_BITS-1:0]   m1_q;
	logic                  ovf_q;
	logic [2*MUL_BITS-1:0] prod_q, acc_q;

	logic                  out_valid_q;
	ndrs_out_t             out_data_q;

	logic                  mul_en;
	logic [MUL_BITS-1:0]   op_a, op_b;
	logic                  accept, out_free;

	logic [MAG_BITS-1:0]   pext, vext;
	logic [MAG_BITS:0]     sum_hi;
	logic [96:0]           wide_sum;
	logic [MAG_BITS-1:0]   xsat;
	logic [XS_BITS-1:0]    xs;
	logic [DIST_BITS-1:0]  cu;
	logic [STATE_BITS-1:0] e_w, vel_new;
	logic [62:0]           mh;
	logic [62:0]           mclamp;
	logic [CMP_BITS-1:0]   idx_next_cmp;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign pext = MAG_BITS'(pos_q);
	assign vext = MAG_BITS'(vel_q);

	assign sum_hi   = {1'b0, prod_q} + {{(MAG_BITS + 1 - 32){1'b0}}, acc_q[63:32]};
	assign wide_sum = {sum_hi, acc_q[31:0]};

	assign xsat = (prod_q > X_ONE) ? X_ONE : prod_q;
	assign xs   = xsat[32:8];
	assign cu   = prod_q[47:24];

	assign e_w     = STATE_BITS'(noise_q) << 8;
	assign vel_new = vsum_q + (pneg_q ? spring_q : (STATE_BITS'(0) - spring_q));

	assign mh     = wide_sum[95:33];
	assign mclamp = pneg_q ? ((ovf_q || mh > SAT_NEG) ? SAT_NEG : mh)
	                       : ((ovf_q || mh > SAT_POS) ? SAT_POS : mh);

	assign idx_next_cmp = CMP_BITS'(idx_q) + CMP_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_en  = 1'b1;
		op_a    = '0;
		op_b    = '0;
		unique case (state_q)
			ST_IDLE: begin
				mul_en = 1'b0;
				if (accept) begin
					state_d = ST_X;
				end
			end
			ST_X: begin
				op_a    = MUL_BITS'(idx_q);
				op_b    = inv_span_q;
				state_d = ST_DB_L;
			end
			ST_DB_L: begin
				op_a    = vmag_q[31:0];
				op_b    = coeff_damping_q;
				state_d = ST_DB_H;
			end
			ST_DB_H: begin
				op_a    = vmag_q[63:32];
				op_b    = coeff_damping_q;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				op_a    = MUL_BITS'(dist_q);
				op_b    = MUL_BITS'(dist_q);
				state_d = ST_SA_L;
			end
			ST_SA_L: begin
				op_a    = pmag_q[31:0];
				op_b    = coeff_spring_q;
				state_d = ST_CU;
			end
			ST_CU: begin
				op_a    = MUL_BITS'(sq_q);
				op_b    = MUL_BITS'(dist_q);
				state_d = ST_SA_H;
			end
			ST_SA_H: begin
				op_a    = pmag_q[63:32];
				op_b    = coeff_spring_q;
				state_d = ST_EN_L;
			end
			ST_EN_L: begin
				op_a    = pmag_q[31:0];
				op_b    = MUL_BITS'(env_q);
				state_d = ST_EN_H;
			end
			ST_EN_H: begin
				op_a    = pmag_q[63:32];
				op_b    = MUL_BITS'(env_q);
				state_d = ST_GN_L;
			end
			ST_GN_L: begin
				mul_en  = 1'b0;
				state_d = ST_GN_H;
			end
			ST_GN_H: begin
				op_a    = m1_q[31:0];
				op_b    = out_gain_q;
				state_d = ST_GN_X;
			end
			ST_GN_X: begin
				op_a    = m1_q[63:32];
				op_b    = out_gain_q;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				mul_en = 1'b0;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				mul_en  = 1'b0;
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_spring_q  <= '0;
			coeff_damping_q <= '0;
			out_gain_q      <= '0;
			note_length_q   <= NOTE_LENGTH_RST;
			inv_span_q      <= INV_SPAN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_COEFF_SPRING:  coeff_spring_q  <= cfg_data;
				REG_COEFF_DAMPING: coeff_damping_q <= cfg_data;
				REG_OUT_GAIN:      out_gain_q      <= cfg_data;
				REG_NOTE_LENGTH:   note_length_q   <= cfg_data[LEN_BITS-1:0];
				REG_INV_SPAN:      inv_span_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			vel_q <= '0;
			idx_q <= '0;
		end else begin
			if (state_q == ST_IDLE && accept && in_data.note_start) begin
				pos_q <= '0;
				vel_q <= '0;
				idx_q <= '0;
			end
			if (state_q == ST_GN_H) begin
				vel_q <= vel_new;
			end
			if (state_q == ST_GN_X) begin
				pos_q <= pos_q + vel_q;
			end
			if (state_q == ST_OUT && out_free && idx_q != {INDEX_BITS{1'b1}}) begin
				idx_q <= idx_q + INDEX_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= (2*MUL_BITS)'(op_a) * (2*MUL_BITS)'(op_b);
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					noise_q <= in_data.noise;
				end
			end
			ST_X: begin
				pneg_q <= pos_q[STATE_BITS-1];
				vneg_q <= vel_q[STATE_BITS-1];
				pmag_q <= pos_q[STATE_BITS-1] ? (MAG_BITS'(0) - pext) : pext;
				vmag_q <= vel_q[STATE_BITS-1] ? (MAG_BITS'(0) - vext) : vext;
			end
			ST_DB_L: begin
				dpos_q <= (xs >= ENV_HALF);
				dist_q <= (xs >= ENV_HALF) ? DIST_BITS'(xs - ENV_HALF)
				                           : DIST_BITS'(ENV_HALF - xs);
			end
			ST_DB_H: acc_q <= prod_q;
			ST_SQ: damp_q <= wide_sum[STATE_BITS+27:28];
			ST_SA_L: sq_q <= prod_q[47:24];
			ST_CU: acc_q <= prod_q;
			ST_SA_H: begin
				env_q <= dpos_q ? (ENV_ONE - (ENV_BITS'(cu) << 3))
				                : (ENV_ONE + (ENV_BITS'(cu) << 3));
			end
			ST_EN_L: spring_q <= wide_sum[STATE_BITS+27:28];
			ST_EN_H: acc_q <= prod_q;
			ST_GN_L: begin
				m1_q   <= wide_sum[87:24];
				ovf_q  <= |wide_sum[96:88];
				vsum_q <= vel_q + e_w + (vneg_q ? damp_q : (STATE_BITS'(0) - damp_q));
			end
			ST_GN_H: begin
			end
			ST_GN_X: acc_q <= prod_q;
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_data_q.sample <= pneg_q ? (SAMPLE_BITS'(0) - mclamp[SAMPLE_BITS-1:0])
			                            : mclamp[SAMPLE_BITS-1:0];
			out_data_q.last   <= (idx_next_cmp == CMP_BITS'(note_length_q));
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_X)
		else $error("accepted transaction did not start the sequence");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> (out_valid && state_q == ST_IDLE))
		else $error("result not loaded into output register");

	a_index_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_OUT && !accept) |=> $stable(idx_q))
		else $error("sample index moved outside result hand-off");

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EN_L) |-> (env_q <= ENV_LIMIT))
		else $error("envelope beyond two");

	a_out_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !out_free) |=> (state_q == ST_OUT && $stable(out_data)))
		else $error("result overwrote a stalled transaction");

endmodule

`default_nettype wire
